### sv/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Shared widths, operator and status codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int VALUE_W   = 32;
  localparam int SYM_W     = 8;
  localparam int OPD_DEPTH = 16;
  localparam int OPR_DEPTH = 16;
  localparam int OPD_CW    = $clog2(OPD_DEPTH + 1);
  localparam int OPD_IW    = $clog2(OPD_DEPTH);
  localparam int OPR_CW    = $clog2(OPR_DEPTH + 1);
  localparam int OPR_IW    = $clog2(OPR_DEPTH);
  localparam int DIV_CW    = $clog2(VALUE_W + 1);

  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;

  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_LPAREN = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2,
    ST_MALF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SK_OPERAND = 2'd0,
    SK_OP      = 2'd1,
    SK_LPAREN  = 2'd2,
    SK_RPAREN  = 2'd3
  } sym_kind_t;

  typedef enum logic [1:0] {
    RD_TOP  = 2'd0,
    RD_NEXT = 2'd1,
    RD_BASE = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    push_num;
    logic    push_op;
    logic    pop_op;
    logic    set_malf;
    logic    set_divz;
    rd_sel_t rd_sel;
    logic    latch_b;
    logic    div_start;
    logic    wr_result;
    logic    end_chk;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    sym_kind_t kind;
    logic      last;
    logic      err_ok;
    logic      opr_empty;
    logic      top_lparen;
    logic      top_prio_ge;
    logic      cur_lparen;
    logic      cur_div;
    logic      opd_lt2;
    logic      opd_one;
    logic      b_zero;
    logic      div_done;
    logic      out_free;
  } stat_t;

  function automatic sym_kind_t sym_kind(input logic [SYM_W-1:0] sym);
    sym_kind_t k;
    unique case (sym) inside
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: k = SK_OP;
      CH_LPAREN: k = SK_LPAREN;
      CH_RPAREN: k = SK_RPAREN;
      default:   k = SK_OPERAND;
    endcase
    return k;
  endfunction

  function automatic opcode_t sym_opcode(input logic [SYM_W-1:0] sym);
    opcode_t op;
    unique case (sym)
      CH_MINUS:  op = OP_SUB;
      CH_STAR:   op = OP_MUL;
      CH_SLASH:  op = OP_DIV;
      CH_LPAREN: op = OP_LPAREN;
      default:   op = OP_ADD;
    endcase
    return op;
  endfunction

  function automatic logic prio_high(input opcode_t op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage

### sv/infix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Evaluates an infix expression of single-digit operands, + - * / and
// parentheses, one character per beat, with two bounded stacks.
//
//   Channel | Direction | tdata          | tuser       | tlast
//   in_     | slave     | [7:0] symbol   | -           | last
//   out_    | master    | [31:0] value   | [1:0] status| -
//
// An operand or a left parenthesis is loaded, decoded and pushed; an
// operator or a right parenthesis first runs its reductions, each by
// + - or * or by a division on the one-bit-per-cycle divider. The last
// character adds the final reductions and the result. Reset is
// synchronous and active low and empties both stacks. A stalled result
// holds in the output register while the next expression is taken in.
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  iee_pkg::cmd_t    cmd;
  iee_pkg::stat_t   stat;
  iee_pkg::value_t  value;
  iee_pkg::status_t status;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iee_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_symbol  (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (value),
    .out_status (status)
  );

  assign out_tdata = value;
  assign out_tuser = status;

endmodule

### sv/iee_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module iee_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  iee_pkg::value_t dividend,
  input  iee_pkg::value_t divisor,
  output logic            done,
  output iee_pkg::value_t quot
);

  logic                       busy_r;
  logic                       done_r;
  logic                       neg_r;
  logic [iee_pkg::DIV_CW-1:0] cnt_r;
  iee_pkg::value_t            rem_r;
  iee_pkg::value_t            quo_r;
  iee_pkg::value_t            den_r;
  logic [iee_pkg::VALUE_W:0]  rem_sh;
  logic [iee_pkg::VALUE_W:0]  diff;
  logic                       ge;

  assign rem_sh = {rem_r, quo_r[iee_pkg::VALUE_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == iee_pkg::DIV_CW'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[iee_pkg::VALUE_W-1] ? -dividend : dividend;
      den_r <= divisor[iee_pkg::VALUE_W-1] ? -divisor : divisor;
      rem_r <= '0;
      neg_r <= dividend[iee_pkg::VALUE_W-1] ^ divisor[iee_pkg::VALUE_W-1];
      cnt_r <= iee_pkg::DIV_CW'(iee_pkg::VALUE_W);
    end else if (busy_r) begin
      quo_r <= {quo_r[iee_pkg::VALUE_W-2:0], ge};
      rem_r <= ge ? diff[iee_pkg::VALUE_W-1:0] : rem_sh[iee_pkg::VALUE_W-1:0];
      cnt_r <= cnt_r - iee_pkg::DIV_CW'(1);
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -quo_r : quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("Divider started while busy.");

endmodule

### sv/iee_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator datapath
// Operand stack memory, operator stack, counts, sticky error, arithmetic
// unit with iterative divider, and the result register.
// ----------------------------------------------------------------------------
module iee_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  iee_pkg::cmd_t             cmd,
  output iee_pkg::stat_t            stat,
  input  logic [iee_pkg::SYM_W-1:0] in_symbol,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output iee_pkg::value_t           out_value,
  output iee_pkg::status_t          out_status
);

  logic [iee_pkg::SYM_W-1:0]  sym_r;
  logic                       last_r;
  iee_pkg::opcode_t           sym_op;

  iee_pkg::value_t            opd_mem [iee_pkg::OPD_DEPTH];
  iee_pkg::value_t            rd_data_r;
  iee_pkg::value_t            b_r;
  logic [iee_pkg::OPD_CW-1:0] opd_cnt_r;
  logic [iee_pkg::OPD_CW-1:0] opd_cnt_nxt;
  logic [iee_pkg::OPD_CW-1:0] opd_m1;
  logic [iee_pkg::OPD_CW-1:0] opd_m2;
  logic                       opd_full;
  logic [iee_pkg::OPD_IW-1:0] opd_raddr;
  logic [iee_pkg::OPD_IW-1:0] opd_waddr;
  logic                       opd_we;
  iee_pkg::value_t            opd_wdata;

  iee_pkg::opcode_t           opr_stk_r [iee_pkg::OPR_DEPTH];
  logic [iee_pkg::OPR_CW-1:0] opr_cnt_r;
  logic [iee_pkg::OPR_CW-1:0] opr_cnt_nxt;
  logic [iee_pkg::OPR_CW-1:0] opr_m1;
  logic                       opr_full;
  iee_pkg::opcode_t           opr_top;
  iee_pkg::opcode_t           cur_op_r;

  iee_pkg::status_t           err_r;
  iee_pkg::status_t           err_nxt;
  iee_pkg::value_t            alu_res;
  iee_pkg::value_t            div_q;
  logic                       div_done;

  logic                       out_valid_r;
  iee_pkg::value_t            out_value_r;
  iee_pkg::status_t           out_status_r;

  assign sym_op   = iee_pkg::sym_opcode(sym_r);
  assign opd_m1   = opd_cnt_r - iee_pkg::OPD_CW'(1);
  assign opd_m2   = opd_cnt_r - iee_pkg::OPD_CW'(2);
  assign opd_full = (opd_cnt_r == iee_pkg::OPD_CW'(iee_pkg::OPD_DEPTH));
  assign opr_m1   = opr_cnt_r - iee_pkg::OPR_CW'(1);
  assign opr_full = (opr_cnt_r == iee_pkg::OPR_CW'(iee_pkg::OPR_DEPTH));
  assign opr_top  = opr_stk_r[opr_m1[iee_pkg::OPR_IW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (cmd.latch_b) begin
      b_r <= rd_data_r;
    end
    if (cmd.pop_op) begin
      cur_op_r <= opr_top;
    end
    if (cmd.push_op && !opr_full) begin
      opr_stk_r[opr_cnt_r[iee_pkg::OPR_IW-1:0]] <= sym_op;
    end
  end

  always_comb begin
    case (cur_op_r)
      iee_pkg::OP_ADD: alu_res = rd_data_r + b_r;
      iee_pkg::OP_SUB: alu_res = rd_data_r - b_r;
      iee_pkg::OP_MUL: alu_res = rd_data_r * b_r;
      default:         alu_res = div_q;
    endcase
  end

  iee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_data_r),
    .divisor  (b_r),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    case (cmd.rd_sel)
      iee_pkg::RD_TOP:  opd_raddr = opd_m1[iee_pkg::OPD_IW-1:0];
      iee_pkg::RD_NEXT: opd_raddr = opd_m2[iee_pkg::OPD_IW-1:0];
      default:          opd_raddr = '0;
    endcase
    opd_we    = cmd.wr_result || (cmd.push_num && !opd_full);
    opd_waddr = cmd.wr_result ? opd_m2[iee_pkg::OPD_IW-1:0]
                              : opd_cnt_r[iee_pkg::OPD_IW-1:0];
    opd_wdata = cmd.wr_result ? alu_res
                              : iee_pkg::VALUE_W'(sym_r) - iee_pkg::VALUE_W'(iee_pkg::CH_ZERO);
  end

  always_ff @(posedge clk) begin
    if (opd_we) begin
      opd_mem[opd_waddr] <= opd_wdata;
    end
    rd_data_r <= opd_mem[opd_raddr];
  end

  always_comb begin
    opd_cnt_nxt = opd_cnt_r;
    opr_cnt_nxt = opr_cnt_r;
    err_nxt     = err_r;
    if (cmd.push_num && !opd_full) begin
      opd_cnt_nxt = opd_cnt_r + iee_pkg::OPD_CW'(1);
    end else if (cmd.wr_result) begin
      opd_cnt_nxt = opd_m1;
    end
    if (cmd.push_op && !opr_full) begin
      opr_cnt_nxt = opr_cnt_r + iee_pkg::OPR_CW'(1);
    end else if (cmd.pop_op) begin
      opr_cnt_nxt = opr_m1;
    end
    if (err_r == iee_pkg::ST_OK) begin
      if ((cmd.push_num && opd_full) || (cmd.push_op && opr_full)) begin
        err_nxt = iee_pkg::ST_OVF;
      end else if (cmd.set_malf || (cmd.end_chk && !stat.opd_one)) begin
        err_nxt = iee_pkg::ST_MALF;
      end else if (cmd.set_divz) begin
        err_nxt = iee_pkg::ST_DIVZ;
      end
    end
    if (cmd.emit) begin
      opd_cnt_nxt = '0;
      opr_cnt_nxt = '0;
      err_nxt     = iee_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opd_cnt_r   <= '0;
      opr_cnt_r   <= '0;
      err_r       <= iee_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      opd_cnt_r <= opd_cnt_nxt;
      opr_cnt_r <= opr_cnt_nxt;
      err_r     <= err_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= (err_r == iee_pkg::ST_OK) ? rd_data_r : '0;
      out_status_r <= err_r;
    end
  end

  assign stat.kind        = iee_pkg::sym_kind(sym_r);
  assign stat.last        = last_r;
  assign stat.err_ok      = (err_r == iee_pkg::ST_OK);
  assign stat.opr_empty   = (opr_cnt_r == '0);
  assign stat.top_lparen  = (opr_top == iee_pkg::OP_LPAREN);
  assign stat.top_prio_ge = iee_pkg::prio_high(opr_top) || !iee_pkg::prio_high(sym_op);
  assign stat.cur_lparen  = (cur_op_r == iee_pkg::OP_LPAREN);
  assign stat.cur_div     = (cur_op_r == iee_pkg::OP_DIV);
  assign stat.opd_lt2     = (opd_cnt_r < iee_pkg::OPD_CW'(2));
  assign stat.opd_one     = (opd_cnt_r == iee_pkg::OPD_CW'(1));
  assign stat.b_zero      = (b_r == '0);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_wr_two: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_result |-> (opd_cnt_r >= iee_pkg::OPD_CW'(2)))
    else $error("Reduction written back with fewer than two operands.");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (opd_cnt_r == '0) && (opr_cnt_r == '0) && (err_r == iee_pkg::ST_OK))
    else $error("Stacks or error not cleared after a result.");

endmodule

### sv/iee_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator controller
// Sequences decoding, operator reduction loops, operand reads, arithmetic
// and the final reduction and result for each expression.
// ----------------------------------------------------------------------------
module iee_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  iee_pkg::stat_t stat,
  output iee_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DEC  = 11'b000_0000_0010,
    S_OPL  = 11'b000_0000_0100,
    S_RPL  = 11'b000_0000_1000,
    S_APC  = 11'b000_0001_0000,
    S_APA  = 11'b000_0010_0000,
    S_APE  = 11'b000_0100_0000,
    S_APD  = 11'b000_1000_0000,
    S_POST = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  state_t ret_r;
  state_t ret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    cmd.rd_sel = iee_pkg::RD_BASE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.err_ok) begin
          state_nxt = S_POST;
        end else begin
          unique case (stat.kind)
            iee_pkg::SK_OPERAND: begin
              cmd.push_num = 1'b1;
              state_nxt    = S_POST;
            end
            iee_pkg::SK_LPAREN: begin
              cmd.push_op = 1'b1;
              state_nxt   = S_POST;
            end
            iee_pkg::SK_RPAREN: state_nxt = S_RPL;
            default:            state_nxt = S_OPL;
          endcase
        end
      end
      S_OPL: begin
        if (!stat.err_ok) begin
          state_nxt = S_POST;
        end else if (!stat.opr_empty && !stat.top_lparen && stat.top_prio_ge) begin
          cmd.pop_op = 1'b1;
          ret_nxt    = S_OPL;
          state_nxt  = S_APC;
        end else begin
          cmd.push_op = 1'b1;
          state_nxt   = S_POST;
        end
      end
      S_RPL: begin
        if (!stat.err_ok) begin
          state_nxt = S_POST;
        end else if (stat.opr_empty) begin
          cmd.set_malf = 1'b1;
          state_nxt    = S_POST;
        end else begin
          cmd.pop_op = 1'b1;
          if (stat.top_lparen) begin
            state_nxt = S_POST;
          end else begin
            ret_nxt   = S_RPL;
            state_nxt = S_APC;
          end
        end
      end
      S_APC: begin
        if (stat.cur_lparen || stat.opd_lt2) begin
          cmd.set_malf = 1'b1;
          state_nxt    = ret_r;
        end else begin
          cmd.rd_sel = iee_pkg::RD_TOP;
          state_nxt  = S_APA;
        end
      end
      S_APA: begin
        cmd.latch_b = 1'b1;
        cmd.rd_sel  = iee_pkg::RD_NEXT;
        state_nxt   = S_APE;
      end
      S_APE: begin
        if (!stat.cur_div) begin
          cmd.wr_result = 1'b1;
          state_nxt     = ret_r;
        end else if (stat.b_zero) begin
          cmd.set_divz = 1'b1;
          state_nxt    = ret_r;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_APD;
        end
      end
      S_APD: begin
        if (stat.div_done) begin
          cmd.wr_result = 1'b1;
          state_nxt     = ret_r;
        end
      end
      S_POST: begin
        state_nxt = stat.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!stat.opr_empty && stat.err_ok) begin
          cmd.pop_op = 1'b1;
          ret_nxt    = S_FIN;
          state_nxt  = S_APC;
        end else begin
          cmd.end_chk = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_FIN;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_APD) && !in_ready)
    else $error("Controller left the division wait early.");

  a_ret_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APC) |-> (ret_r == S_OPL) || (ret_r == S_RPL) || (ret_r == S_FIN))
    else $error("Reduction started without a valid return point.");

endmodule
